// ===== src/hdlctx_pkg.sv =====
`default_nettype none

package hdlctx_pkg;

  // command codes carried on mode_i
  typedef enum logic [2:0] {
    MODE_START = 3'd0,
    MODE_FLAG  = 3'd1,
    MODE_DATA  = 3'd2,
    MODE_ADDR  = 3'd3,
    MODE_FCS   = 3'd4,
    MODE_FLUSH = 3'd5
  } mode_e;

  localparam logic [7:0]  FlagByte  = 8'h7E;
  localparam logic [15:0] CrcPoly   = 16'h8408;
  localparam logic [15:0] CrcInit   = 16'hFFFF;
  localparam int          FifoDepth = 4;
  localparam int          StuffRun  = 5;

  // one byte after stuffing and nrzi: up to ten coded levels, oldest in the msb
  typedef struct packed {
    logic [9:0] seq;
    logic [3:0] n;
    logic [2:0] ones;
    logic       level;
  } stuff_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } fifo_ent_t;

  // crc-16/x.25, reflected, one byte lsb first
  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (r[0]) begin
        r = (r >> 1) ^ CrcPoly;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  // eight line bits lsb first, optional zero insertion, nrzi coding
  function automatic stuff_t stuff_byte(input logic [7:0] b, input logic en,
                                        input logic [2:0] ones, input logic level);
    stuff_t     r;
    logic [2:0] o;
    logic       lv;
    logic [9:0] s;
    logic [3:0] n;
    logic       bt;
    o  = ones;
    lv = level;
    s  = '0;
    n  = '0;
    for (int i = 0; i < 8; i++) begin
      bt = b[i];
      if (!bt) begin
        lv = ~lv;
      end
      s = {s[8:0], lv};
      n = n + 4'd1;
      if (bt) begin
        if (o != 3'd7) begin
          o = o + 3'd1;
        end
      end else begin
        o = 3'd0;
      end
      if (en && (o >= 3'(StuffRun))) begin
        lv = ~lv;
        s  = {s[8:0], lv};
        n  = n + 4'd1;
        o  = 3'd0;
      end
    end
    r.seq   = s;
    r.n     = n;
    r.ones  = o;
    r.level = lv;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/hdlc_frame_bit_stuff_nrzi_tx.sv =====
`default_nettype none

// channel   | handshake                | payload
// ----------+--------------------------+-------------------------------------
// command   | in_valid_i / in_stall_o  | mode_i, data_byte_i, address_last_i
// result    | out_valid_o / out_stall_i| out_byte_o, run_last_o
//
// a request lands in the command register; once two queue entries are free its line bytes move
// from there into the four-entry queue, where the result port reads them
// an fcs command advances once per byte before it leaves the command register,
// and the register advances only with two free queue entries
// sustained rate is bounded by the result port, one byte per cycle; a result-side stall
// fills the queue and then stalls the command side; rst_ni clears state and queue and sets crc to its init value

module hdlc_frame_bit_stuff_nrzi_tx (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [2:0] mode_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       address_last_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic      [7:0] out_byte_o,
  output logic            run_last_o
);

  localparam int Depth = hdlctx_pkg::FifoDepth;
  localparam int IdxW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  // command register
  logic       cmd_valid_q;
  logic [2:0] cmd_mode_q;
  logic [7:0] cmd_byte_q;
  logic       cmd_last_q;
  logic       fcs_phase_q, fcs_phase_d;

  // line state
  logic        level_q, level_d;
  logic [7:0]  acc_q, acc_d;
  logic [2:0]  held_q, held_d;
  logic [2:0]  ones_q, ones_d;
  logic [15:0] crc_q, crc_d;

  // result queue
  hdlctx_pkg::fifo_ent_t mem_q [Depth];
  logic [IdxW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic [1:0]      push_n;
  hdlctx_pkg::fifo_ent_t push0, push1;
  logic            pop;

  logic fifo_room;
  logic advance;
  logic op_last;

  // byte path signals
  logic [7:0]         op_byte;
  logic               op_stuff;
  logic [15:0]        fcs;
  hdlctx_pkg::stuff_t so;
  logic [17:0]        comb_bits;
  logic [4:0]         total;
  logic [17:0]        sh_hi, sh_lo;
  logic [2:0]         rem;
  logic [7:0]         flush_byte;

  assign fifo_room  = cnt_q <= CntW'(Depth - 2);
  assign advance    = cmd_valid_q && fifo_room;
  assign op_last    = (cmd_mode_q != hdlctx_pkg::MODE_FCS) || fcs_phase_q;
  assign in_stall_o = cmd_valid_q && !(fifo_room && op_last);

  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = cnt_q != '0;
  assign out_byte_o  = mem_q[rd_q].data;
  assign run_last_o  = mem_q[rd_q].last;

  // pick the byte that goes on the line this cycle
  assign fcs = ~crc_q;
  always_comb begin
    op_stuff = 1'b1;
    case (cmd_mode_q)
      hdlctx_pkg::MODE_FLAG: begin
        op_byte  = hdlctx_pkg::FlagByte;
        op_stuff = 1'b0;
      end
      hdlctx_pkg::MODE_ADDR: op_byte = {cmd_byte_q[6:0], cmd_last_q};
      hdlctx_pkg::MODE_FCS:  op_byte = fcs_phase_q ? fcs[15:8] : fcs[7:0];
      default:               op_byte = cmd_byte_q;
    endcase
  end

  assign so = hdlctx_pkg::stuff_byte(op_byte, op_stuff, ones_q, level_q);

  // held bits followed by the new coded levels, newest in the lsb
  assign comb_bits  = ({10'd0, acc_q} << so.n) | {8'd0, so.seq};
  assign total      = {2'b00, held_q} + {1'b0, so.n};
  assign sh_hi      = comb_bits >> (total - 5'd8);
  assign sh_lo      = comb_bits >> (total - 5'd16);
  assign rem        = total[2:0];
  assign flush_byte = acc_q << (4'd8 - {1'b0, held_q});

  always_comb begin
    level_d     = level_q;
    acc_d       = acc_q;
    held_d      = held_q;
    ones_d      = ones_q;
    crc_d       = crc_q;
    fcs_phase_d = fcs_phase_q;
    push_n      = 2'd0;
    push0       = '{data: sh_hi[7:0], last: 1'b0};
    push1       = '{data: sh_lo[7:0], last: op_last};
    if (advance) begin
      case (cmd_mode_q)
        hdlctx_pkg::MODE_START: begin
          level_d = 1'b0;
          acc_d   = '0;
          held_d  = '0;
          ones_d  = '0;
          crc_d   = hdlctx_pkg::CrcInit;
        end
        hdlctx_pkg::MODE_FLAG, hdlctx_pkg::MODE_DATA,
        hdlctx_pkg::MODE_ADDR, hdlctx_pkg::MODE_FCS: begin
          level_d = so.level;
          ones_d  = so.ones;
          held_d  = rem;
          // keep only the bits still waiting for a byte
          acc_d   = comb_bits[7:0] & ~(8'hFF << rem);
          if (total >= 5'd16) begin
            push_n = 2'd2;
          end else if (total >= 5'd8) begin
            push_n     = 2'd1;
            push0.last = op_last;
          end
          if (cmd_mode_q == hdlctx_pkg::MODE_DATA || cmd_mode_q == hdlctx_pkg::MODE_ADDR) begin
            crc_d = hdlctx_pkg::crc_byte(crc_q, op_byte);
          end
          if (cmd_mode_q == hdlctx_pkg::MODE_FCS) begin
            fcs_phase_d = ~fcs_phase_q;
          end
        end
        hdlctx_pkg::MODE_FLUSH: begin
          if (held_q != '0) begin
            push_n = 2'd1;
            push0  = '{data: flush_byte, last: 1'b1};
            acc_d  = '0;
            held_d = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
      fcs_phase_q <= 1'b0;
      level_q     <= 1'b0;
      acc_q       <= '0;
      held_q      <= '0;
      ones_q      <= '0;
      crc_q       <= hdlctx_pkg::CrcInit;
      wr_q        <= '0;
      rd_q        <= '0;
      cnt_q       <= '0;
    end else begin
      if (!in_stall_o) begin
        cmd_valid_q <= in_valid_i;
      end
      fcs_phase_q <= fcs_phase_d;
      level_q     <= level_d;
      acc_q       <= acc_d;
      held_q      <= held_d;
      ones_q      <= ones_d;
      crc_q       <= crc_d;
      wr_q        <= wr_q + IdxW'(push_n);
      rd_q        <= rd_q + IdxW'(pop);
      cnt_q       <= cnt_q + CntW'(push_n) - CntW'(pop);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      cmd_mode_q <= mode_i;
      cmd_byte_q <= data_byte_i;
      cmd_last_q <= address_last_i;
    end
    if (push_n != 2'd0) begin
      mem_q[wr_q] <= push0;
    end
    if (push_n == 2'd2) begin
      mem_q[wr_q + IdxW'(1)] <= push1;
    end
  end

`ifndef SYNTH
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("result queue over depth");

  a_acc_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_q >> held_q) == 8'd0)
    else $error("bits above the held count are set");

  a_start_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && cmd_mode_q == hdlctx_pkg::MODE_START
    |=> crc_q == hdlctx_pkg::CrcInit && held_q == 3'd0 && !level_q)
    else $error("start frame did not clear state");

  a_fcs_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcs_phase_q |-> cmd_valid_q && cmd_mode_q == hdlctx_pkg::MODE_FCS)
    else $error("fcs second byte without fcs command");

  a_fcs_crc_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && cmd_mode_q == hdlctx_pkg::MODE_FCS |=> $stable(crc_q))
    else $error("crc changed during fcs");
`endif

endmodule

`default_nettype wire

// ===== bench/hdlc_frame_bit_stuff_nrzi_tx_test.sv =====
`default_nettype none

module hdlc_frame_bit_stuff_nrzi_tx_test;
  timeunit 1ns;
  timeprecision 1ps;

  // reserved command codes, the block must ignore them
  localparam logic [2:0] ModeSpare6 = 3'd6;
  localparam logic [2:0] ModeSpare7 = 3'd7;

  localparam int DirectedRows  = 25;
  localparam int RandomTarget  = 280;
  localparam int HoldOffCycles = 300;
  // longest correct quiet spell is the hold-off plus a few short stalls
  localparam int QuietLimit    = 4000;
  localparam int SettleCycles  = 16;
  localparam int ReportLimit   = 10;

  // one request on the command side; typed rows carry their line bytes inline
  typedef struct {
    logic [2:0] mode;
    logic [7:0] data;
    logic       addr_last;
    bit         typed;
    int         typed_n;
    logic [7:0] typed_first;
    logic [7:0] typed_second;
  } command_t;

  // one coded byte on the result side
  typedef struct {
    logic [7:0] out_byte;
    logic       run_last;
  } line_byte_t;

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       in_valid_i     = 1'b0;
  logic [2:0] mode_i         = hdlctx_pkg::MODE_START;
  logic [7:0] data_byte_i    = 8'h00;
  logic       address_last_i = 1'b0;
  logic       out_stall_i    = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       run_last_o;

  hdlc_frame_bit_stuff_nrzi_tx dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .data_byte_i    (data_byte_i),
    .address_last_i (address_last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .run_last_o     (run_last_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // line bytes still owed by the block, oldest first
  line_byte_t line_bytes_due_q[$];
  // line bytes worked out for the request just accepted
  line_byte_t line_bytes_new_q[$];

  // transmitter state as the predictor sees it
  logic        nrzi_level;
  logic [7:0]  shift_acc;
  int          held_bits;
  logic [2:0]  ones_count;
  logic [15:0] fcs_crc;

  int  mismatches;
  int  commands_sent;
  int  frames_closed;
  int  bytes_checked;
  int  most_per_command;
  int  burst_left;
  bit  hold_off_req;
  bit  hold_off_done;

  command_t directed_rows[DirectedRows];

  // crc-16/x.25 over one byte, lsb first
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ hdlctx_pkg::CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // one bit onto the line: nrzi code it, pack it, hand off full bytes
  task automatic put_line_bit(input logic b);
    line_byte_t full;
    if (!b) begin
      nrzi_level = ~nrzi_level;
    end
    shift_acc = {shift_acc[6:0], nrzi_level};
    held_bits++;
    if (held_bits == 8) begin
      full.out_byte = shift_acc;
      full.run_last = 1'b0;
      line_bytes_new_q.push_back(full);
      held_bits = 0;
      shift_acc = 8'h00;
    end
  endtask

  // eight bits lsb first, with zero insertion after five ones when stuffing
  task automatic put_line_byte(input logic [7:0] b, input logic stuffing);
    for (int i = 0; i < 8; i++) begin
      put_line_bit(b[i]);
      if (b[i]) begin
        if (ones_count != 3'd7) begin
          ones_count = ones_count + 3'd1;
        end
      end else begin
        ones_count = 3'd0;
      end
      if (stuffing && ones_count >= 3'd5) begin
        put_line_bit(1'b0);
        ones_count = 3'd0;
      end
    end
  endtask

  task automatic reset_line_state();
    nrzi_level = 1'b0;
    shift_acc  = 8'h00;
    held_bits  = 0;
    ones_count = 3'd0;
    fcs_crc    = hdlctx_pkg::CrcInit;
  endtask

  // works out the line bytes one request causes and advances the state
  task automatic predict_line_bytes(input logic [2:0] mode, input logic [7:0] data,
                                    input logic addr_last);
    logic [7:0]  addr;
    logic [15:0] fcs;
    line_byte_t  part;
    line_bytes_new_q.delete();
    case (mode)
      hdlctx_pkg::MODE_START: begin
        reset_line_state();
      end
      hdlctx_pkg::MODE_FLAG: begin
        put_line_byte(hdlctx_pkg::FlagByte, 1'b0);
      end
      hdlctx_pkg::MODE_DATA: begin
        fcs_crc = crc_step(fcs_crc, data);
        put_line_byte(data, 1'b1);
      end
      hdlctx_pkg::MODE_ADDR: begin
        addr    = {data[6:0], addr_last};
        fcs_crc = crc_step(fcs_crc, addr);
        put_line_byte(addr, 1'b1);
      end
      hdlctx_pkg::MODE_FCS: begin
        // fcs does not enter the crc, low byte goes first
        fcs = ~fcs_crc;
        put_line_byte(fcs[7:0], 1'b1);
        put_line_byte(fcs[15:8], 1'b1);
      end
      hdlctx_pkg::MODE_FLUSH: begin
        // partial byte goes out left-aligned; level and ones run are kept
        if (held_bits != 0) begin
          part.out_byte = shift_acc << (8 - held_bits);
          part.run_last = 1'b0;
          line_bytes_new_q.push_back(part);
          shift_acc = 8'h00;
          held_bits = 0;
        end
      end
      default: begin
      end
    endcase
    if (line_bytes_new_q.size() > 0) begin
      line_bytes_new_q[line_bytes_new_q.size() - 1].run_last = 1'b1;
    end
    if (line_bytes_new_q.size() > most_per_command) begin
      most_per_command = line_bytes_new_q.size();
    end
  endtask

  // sender gap: valid drops for a random number of cycles, then a new burst
  task automatic sender_gap();
    int gap;
    gap = $urandom_range(1, 10);
    @(negedge clk_i);
    in_valid_i     <= 1'b0;
    mode_i         <= 3'($urandom_range(0, 7));
    data_byte_i    <= 8'($urandom_range(0, 255));
    address_last_i <= 1'($urandom_range(0, 1));
    repeat (gap - 1) @(negedge clk_i);
    // now and then a long burst with no idling at all
    burst_left = ($urandom_range(0, 9) < 3) ? $urandom_range(40, 80) : $urandom_range(1, 12);
  endtask

  // offers one request, holds it until taken, then books its line bytes
  task automatic issue_command(input command_t cmd);
    line_byte_t entry;
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    mode_i         <= cmd.mode;
    data_byte_i    <= cmd.data;
    address_last_i <= cmd.addr_last;
    do @(posedge clk_i); while (in_stall_o);
    predict_line_bytes(cmd.mode, cmd.data, cmd.addr_last);
    if (cmd.typed) begin
      for (int k = 0; k < cmd.typed_n; k++) begin
        entry.out_byte = (k == 0) ? cmd.typed_first : cmd.typed_second;
        entry.run_last = (k == cmd.typed_n - 1);
        line_bytes_due_q.push_back(entry);
      end
    end else begin
      foreach (line_bytes_new_q[k]) begin
        line_bytes_due_q.push_back(line_bytes_new_q[k]);
      end
    end
    if (cmd.mode <= hdlctx_pkg::MODE_FLUSH) begin
      commands_sent++;
    end
    if (cmd.mode == hdlctx_pkg::MODE_FCS) begin
      frames_closed++;
    end
    burst_left--;
    if (burst_left <= 0) begin
      sender_gap();
    end
  endtask

  task automatic send_plain(input logic [2:0] mode, input logic [7:0] data,
                            input logic addr_last);
    command_t cmd;
    cmd = '{mode, data, addr_last, 1'b0, 0, 8'h00, 8'h00};
    issue_command(cmd);
  endtask

  // sender stops and waits until the block has delivered everything owed
  task automatic drain_line_bytes();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (line_bytes_due_q.size() != 0) @(posedge clk_i);
  endtask

  // payload bytes leaning toward long runs of ones so stuffing fires often
  function automatic logic [7:0] pick_payload();
    case ($urandom_range(0, 7))
      0, 1:    return 8'hFF;
      2:       return hdlctx_pkg::FlagByte;
      3:       return ~(8'h01 << $urandom_range(0, 7));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one well-formed frame with random content
  task automatic send_frame();
    int n_addr;
    int n_data;
    if ($urandom_range(0, 3) != 0) begin
      send_plain(hdlctx_pkg::MODE_START, 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)));
    end
    repeat ($urandom_range(1, 2)) begin
      send_plain(hdlctx_pkg::MODE_FLAG, 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)));
    end
    n_addr = $urandom_range(1, 3);
    for (int k = 0; k < n_addr; k++) begin
      // extension bit marks the last address byte
      send_plain(hdlctx_pkg::MODE_ADDR, pick_payload(), k == n_addr - 1);
    end
    n_data = $urandom_range(0, 6);
    repeat (n_data) begin
      send_plain(hdlctx_pkg::MODE_DATA, pick_payload(), 1'($urandom_range(0, 1)));
    end
    send_plain(hdlctx_pkg::MODE_FCS, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    repeat ($urandom_range(1, 2)) begin
      send_plain(hdlctx_pkg::MODE_FLAG, 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)));
    end
    if ($urandom_range(0, 1) != 0) begin
      send_plain(hdlctx_pkg::MODE_FLUSH, 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)));
    end
  endtask

  // a few arbitrary requests, spare codes included
  task automatic send_noise();
    repeat ($urandom_range(1, 4)) begin
      send_plain(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic note_mismatch(input string what, input int wanted, input int seen);
    mismatches++;
    if (mismatches <= ReportLimit) begin
      $display("mismatch at %0t: %s expected %02h got %02h", $realtime, what, wanted, seen);
    end
  endtask

  // result checker
  always @(posedge clk_i) begin : result_check
    line_byte_t due;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (line_bytes_due_q.size() == 0) begin
        note_mismatch("line byte with nothing owed", 0, out_byte_o);
      end else begin
        due = line_bytes_due_q.pop_front();
        if (out_byte_o !== due.out_byte) begin
          note_mismatch("out_byte", due.out_byte, out_byte_o);
        end
        if (run_last_o !== due.run_last) begin
          note_mismatch("run_last", due.run_last, run_last_o);
        end
        bytes_checked++;
      end
    end
  end

  // receiver: stalls on its own patterns, plus one long hold-off on request
  initial begin : receiver
    int kind;
    int span;
    int hold_left;
    hold_left = 0;
    forever begin
      kind = $urandom_range(0, 2);
      span = $urandom_range(10, 60);
      for (int k = 0; k < span; k++) begin
        @(negedge clk_i);
        if (hold_left > 0) begin
          hold_left--;
          out_stall_i <= 1'b1;
        end else if (hold_off_req) begin
          hold_off_req = 1'b0;
          hold_left    = HoldOffCycles - 1;
          out_stall_i  <= 1'b1;
        end else begin
          case (kind)
            0:       out_stall_i <= 1'b0;
            1:       out_stall_i <= 1'($urandom_range(0, 1));
            default: out_stall_i <= ((k % 4) == 3);
          endcase
        end
      end
    end
  end

  // nothing accepted on either side for too long means the block is stuck
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    mismatches       = 0;
    commands_sent    = 0;
    frames_closed    = 0;
    bytes_checked    = 0;
    most_per_command = 0;
    burst_left       = 8;
    hold_off_req     = 1'b0;
    hold_off_done    = 1'b0;
    reset_line_state();

    // directed rows; the typed ones follow straight from the coding rules:
    // a flag from a fresh line is 11111110, an fcs of all zeros toggles every bit
    directed_rows[0]  = '{hdlctx_pkg::MODE_START, 8'h00, 1'b0, 1'b1, 0, 8'h00, 8'h00};
    directed_rows[1]  = '{hdlctx_pkg::MODE_FLUSH, 8'hFF, 1'b1, 1'b1, 0, 8'h00, 8'h00};
    directed_rows[2]  = '{ModeSpare6,             8'hFF, 1'b1, 1'b1, 0, 8'h00, 8'h00};
    directed_rows[3]  = '{ModeSpare7,             8'h00, 1'b0, 1'b1, 0, 8'h00, 8'h00};
    directed_rows[4]  = '{hdlctx_pkg::MODE_FLAG,  8'hA5, 1'b1, 1'b1, 1, 8'hFE, 8'h00};
    directed_rows[5]  = '{hdlctx_pkg::MODE_FLAG,  8'h00, 1'b0, 1'b1, 1, 8'hFE, 8'h00};
    directed_rows[6]  = '{hdlctx_pkg::MODE_ADDR,  8'h00, 1'b0, 1'b0, 0, 8'h00, 8'h00};
    directed_rows[7]  = '{hdlctx_pkg::MODE_ADDR,  8'h7F, 1'b1, 1'b0, 0, 8'h00, 8'h00};
    directed_rows[8]  = '{hdlctx_pkg::MODE_ADDR,  8'hFF, 1'b1, 1'b0, 0, 8'h00, 8'h00};
    directed_rows[9]  = '{hdlctx_pkg::MODE_DATA,  8'h00, 1'b1, 1'b0, 0, 8'h00, 8'h00};
    directed_rows[10] = '{hdlctx_pkg::MODE_DATA,  8'hFF, 1'b0, 1'b0, 0, 8'h00, 8'h00};
    directed_rows[11] = '{hdlctx_pkg::MODE_DATA,  8'hFF, 1'b1, 1'b0, 0, 8'h00, 8'h00};
    directed_rows[12] = '{hdlctx_pkg::MODE_DATA,  8'h7E, 1'b0, 1'b0, 0, 8'h00, 8'h00};
    directed_rows[13] = '{hdlctx_pkg::MODE_DATA,  8'h80, 1'b0, 1'b0, 0, 8'h00, 8'h00};
    directed_rows[14] = '{hdlctx_pkg::MODE_DATA,  8'h01, 1'b1, 1'b0, 0, 8'h00, 8'h00};
    directed_rows[15] = '{hdlctx_pkg::MODE_FCS,   8'h5A, 1'b1, 1'b0, 0, 8'h00, 8'h00};
    directed_rows[16] = '{hdlctx_pkg::MODE_FLAG,  8'hFF, 1'b0, 1'b0, 0, 8'h00, 8'h00};
    directed_rows[17] = '{hdlctx_pkg::MODE_FLUSH, 8'h00, 1'b0, 1'b0, 0, 8'h00, 8'h00};
    // flush right after a flush has nothing left to send
    directed_rows[18] = '{hdlctx_pkg::MODE_FLUSH, 8'h3C, 1'b1, 1'b1, 0, 8'h00, 8'h00};
    directed_rows[19] = '{hdlctx_pkg::MODE_START, 8'hFF, 1'b1, 1'b1, 0, 8'h00, 8'h00};
    // fcs of an empty frame is 0x0000: sixteen toggles, two bytes
    directed_rows[20] = '{hdlctx_pkg::MODE_FCS,   8'h00, 1'b0, 1'b1, 2, 8'hAA, 8'hAA};
    directed_rows[21] = '{hdlctx_pkg::MODE_FLAG,  8'h00, 1'b0, 1'b1, 1, 8'hFE, 8'h00};
    directed_rows[22] = '{hdlctx_pkg::MODE_DATA,  8'hFF, 1'b0, 1'b0, 0, 8'h00, 8'h00};
    directed_rows[23] = '{hdlctx_pkg::MODE_FCS,   8'h00, 1'b0, 1'b0, 0, 8'h00, 8'h00};
    directed_rows[24] = '{hdlctx_pkg::MODE_FLUSH, 8'h00, 1'b0, 1'b0, 0, 8'h00, 8'h00};

    // reset is held at the start, then released away from the rising edge
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < DirectedRows; r++) begin
      issue_command(directed_rows[r]);
    end
    drain_line_bytes();

    // random part: mostly well-formed frames, the rest arbitrary requests
    while (commands_sent < RandomTarget) begin
      if (!hold_off_done && commands_sent >= 110) begin
        // long receiver hold-off while the sender keeps offering requests
        hold_off_req  = 1'b1;
        hold_off_done = 1'b1;
      end
      if ($urandom_range(0, 3) != 0) begin
        send_frame();
      end else begin
        send_noise();
      end
      if (commands_sent >= 200 && commands_sent < 215) begin
        drain_line_bytes();
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (line_bytes_due_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    $display("run covered %0d requests, %0d frames closed with an fcs, %0d line bytes checked",
             commands_sent, frames_closed, bytes_checked);
    $display("up to %0d line bytes from one request, %0d mismatches", most_per_command,
             mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
